@@ rtl/stt_pkg.sv @@
// shared types, token kind codes and keyword tables for the source text tokenizer
// no dependencies; used by stt_lexer, stt_out_queue and source_text_tokenizer
package stt_pkg;

    localparam logic [3:0] KIND_NONE   = 4'd0;
    localparam logic [3:0] KIND_LPAREN = 4'd1;
    localparam logic [3:0] KIND_RPAREN = 4'd2;
    localparam logic [3:0] KIND_LBRACE = 4'd3;
    localparam logic [3:0] KIND_RBRACE = 4'd4;
    localparam logic [3:0] KIND_SEMI   = 4'd5;
    localparam logic [3:0] KIND_OPER   = 4'd6;
    localparam logic [3:0] KIND_ASSIGN = 4'd7;
    localparam logic [3:0] KIND_PRINT  = 4'd8;
    localparam logic [3:0] KIND_INPUT  = 4'd9;
    localparam logic [3:0] KIND_TYPE   = 4'd10;
    localparam logic [3:0] KIND_NUMBER = 4'd11;
    localparam logic [3:0] KIND_IDENT  = 4'd12;

    localparam logic [7:0] CH_DOT   = 8'h2e;
    localparam logic [7:0] CH_BANG  = 8'h21;
    localparam logic [7:0] CH_EQ    = 8'h3d;
    localparam logic [7:0] CH_COLON = 8'h3a;

    // keywords: print, input, int, float
    localparam logic [7:0] KW_TEXT [0:3][0:4] = '{
        '{8'h70, 8'h72, 8'h69, 8'h6e, 8'h74},
        '{8'h69, 8'h6e, 8'h70, 8'h75, 8'h74},
        '{8'h69, 8'h6e, 8'h74, 8'h00, 8'h00},
        '{8'h66, 8'h6c, 8'h6f, 8'h61, 8'h74}
    };
    localparam logic [2:0] KW_LEN [0:3] = '{3'd5, 3'd5, 3'd3, 3'd5};

    typedef struct packed {
        logic [3:0]  kind;
        logic [15:0] start;
        logic [5:0]  length;
        logic        ovf;
        logic        last;
    } t_token;

    // up to two tokens per input byte
    typedef struct packed {
        logic [1:0] cnt;
        t_token     tok0;
        t_token     tok1;
    } t_push;

    function automatic logic is_digit(input logic [7:0] b);
        return (b >= 8'h30) && (b <= 8'h39);
    endfunction

    function automatic logic is_alnum(input logic [7:0] b);
        return is_digit(b) || ((b >= 8'h61) && (b <= 8'h7a)) ||
               ((b >= 8'h41) && (b <= 8'h5a));
    endfunction

    // keyword k still matches when byte b lands at position p
    function automatic logic kw_match(input logic [1:0] k, input logic [7:0] p,
                                      input logic [7:0] b);
        logic hit;
        hit = 1'b0;
        if (p < 8'(KW_LEN[k]))
            hit = (KW_TEXT[k][p[2:0]] == b);
        return hit;
    endfunction

    function automatic logic [3:0] lexeme_kind(input logic [7:0] first, input logic pair,
                                               input logic [3:0] cand, input logic [7:0] cnt,
                                               input logic ovf, input logic dod,
                                               input logic aon);
        logic [3:0] kind;
        logic       sel;
        kind = KIND_NONE;
        sel  = 1'b1;
        case (first)
            8'h28: kind = KIND_LPAREN;
            8'h29: kind = KIND_RPAREN;
            8'h7b: kind = KIND_LBRACE;
            8'h7d: kind = KIND_RBRACE;
            8'h3b: kind = KIND_SEMI;
            8'h2b, 8'h2d, 8'h2a, 8'h2f, 8'h3e, 8'h3c, 8'h3d: kind = KIND_OPER;
            default: sel = 1'b0;
        endcase
        if (!sel) begin
            if (pair && (first == CH_COLON))
                kind = KIND_ASSIGN;
            else if (cand[0] && (cnt == 8'd5) && !ovf)
                kind = KIND_PRINT;
            else if (cand[1] && (cnt == 8'd5) && !ovf)
                kind = KIND_INPUT;
            else if (cand[2] && (cnt == 8'd3) && !ovf)
                kind = KIND_TYPE;
            else if (cand[3] && (cnt == 8'd5) && !ovf)
                kind = KIND_TYPE;
            else if (dod)
                kind = KIND_NUMBER;
            else if (aon)
                kind = KIND_IDENT;
            else
                kind = KIND_NONE;
        end
        return kind;
    endfunction

endpackage

@@ rtl/source_text_tokenizer.sv @@
// top level of the source text tokenizer: byte stream in, token stream out
// depends on stt_pkg, stt_lexer and stt_out_queue
//
// The tokenizer takes one source byte per request on the slave stream and
// returns one request per finished lexeme on the master stream: its kind
// (punctuation, operator, ':=' assign, the keywords print / input / int /
// float, number, identifier or none), its start offset and its length.
// Bytes are classed as blank, alphanumeric or special; runs of alphanumerics
// form one lexeme, ':=' and '!=' are joined, and dots extend a lexeme made
// only of digits and dots. No text is kept: keyword matches and the number /
// identifier status are running flags. Lengths saturate at MAX_LEXEME and
// then set the overflow bit. s_axis_tlast marks the last byte; it flushes
// the open lexeme and returns the block to its reset state, position 0.
// A byte is taken every cycle while the queue has room: the whole per-byte
// update is one pass of logic from the lexer state registers, and tokens
// land in a four-entry queue. One byte gives zero, one or two tokens;
// m_axis_tlast marks the last token due to a byte. Input is held off only
// while the queue has fewer than two free entries, so a downstream that
// takes a token every cycle sees a sustained rate of one byte per cycle,
// also where a byte gives two tokens (a final byte closing two lexemes).
// Tokens are written into the queue registers; the queue head drives m_axis.
module source_text_tokenizer #(
    parameter int MAX_LEXEME    = 63,
    parameter int POSITION_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // byte stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] text_byte
    input  logic        s_axis_tlast,   // end_of_text
    // token stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // [15:0] token_start, [21:16] token_length,
                                        // [22] length_overflow, [23] zero
    output logic [3:0]  m_axis_tuser,   // [3:0] token_kind
    output logic        m_axis_tlast    // run_last
);

    logic            in_accept;
    logic            room;
    stt_pkg::t_push  push;
    stt_pkg::t_token head;

    // a byte is taken whenever the queue can absorb the worst case of two tokens
    assign s_axis_tready = room;
    assign in_accept     = s_axis_tvalid && room;

    stt_lexer #(
        .MAX_LEXEME    (MAX_LEXEME),
        .POSITION_BITS (POSITION_BITS)
    ) u_lexer (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (in_accept),
        .i_byte  (s_axis_tdata),
        .i_last  (s_axis_tlast),
        .o_push  (push)
    );

    // result side: queue decouples downstream stalls from the byte stream
    stt_out_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_room  (room),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_tok   (head)
    );

    assign m_axis_tdata = {1'b0, head.ovf, head.length, head.start};
    assign m_axis_tuser = head.kind;
    assign m_axis_tlast = head.last;

endmodule

@@ rtl/stt_lexer.sv @@
// lexer state and per-byte update: running flags, lexeme bounds, token build
// depends on stt_pkg
module stt_lexer #(
    parameter int MAX_LEXEME    = 63,
    parameter int POSITION_BITS = 16
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  logic [7:0]     i_byte,
    input  logic           i_last,
    output stt_pkg::t_push o_push
);

    localparam int CNT_W = $clog2(MAX_LEXEME + 1);
    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_LEXEME);
    localparam logic [CNT_W-1:0] ONE_CNT = CNT_W'(1);
    localparam logic [CNT_W-1:0] TWO_CNT = CNT_W'(2);

    typedef enum logic [1:0] {
        M_WAIT = 2'd0,
        M_TERM = 2'd1,
        M_SP1  = 2'd2,
        M_SP2  = 2'd3
    } t_mode;

    t_mode                    r_mode, n_mode;
    logic [CNT_W-1:0]         r_count, n_count;
    logic [POSITION_BITS-1:0] r_offset, n_offset;
    logic [POSITION_BITS-1:0] r_pos, n_pos;
    logic [7:0]               r_first, n_first;
    logic [3:0]               r_cand, n_cand;
    logic                     r_dod, n_dod;
    logic                     r_aon, n_aon;
    logic                     r_ovf, n_ovf;

    t_mode           cls;
    logic            emit_a, emit_b;
    logic            do_clear, do_start, do_append;
    logic            b_digit, b_alnum;
    logic [31:0]     len_a, len_b, st_a, st_b;
    stt_pkg::t_token tok_a, tok_b;

    always_comb begin
        b_digit = stt_pkg::is_digit(i_byte);
        b_alnum = stt_pkg::is_alnum(i_byte);
        if ((i_byte == 8'h20) || (i_byte == 8'h0a) || (i_byte == 8'h09))
            cls = M_WAIT;
        else if (b_alnum)
            cls = M_TERM;
        else
            cls = M_SP1;
    end

    always_comb begin
        n_mode    = r_mode;
        n_count   = r_count;
        n_offset  = r_offset;
        n_first   = r_first;
        n_cand    = r_cand;
        n_dod     = r_dod;
        n_aon     = r_aon;
        n_ovf     = r_ovf;
        n_pos     = r_pos + POSITION_BITS'(1);
        emit_a    = 1'b0;
        do_clear  = 1'b0;
        do_start  = 1'b0;
        do_append = 1'b0;

        if (r_mode == M_WAIT) begin
            if (cls != M_WAIT) begin
                do_start = 1'b1;
                n_mode   = cls;
            end
        end else if (cls == M_WAIT) begin
            emit_a   = 1'b1;
            do_clear = 1'b1;
        end else if ((cls == M_SP1) && (i_byte == stt_pkg::CH_DOT) && r_dod) begin
            // dots keep a number going
            do_append = 1'b1;
        end else if (r_mode != cls) begin
            emit_a   = 1'b1;
            do_start = 1'b1;
            n_mode   = cls;
        end else if (r_mode == M_SP1) begin
            if ((r_count == ONE_CNT) && (i_byte == stt_pkg::CH_EQ) &&
                ((r_first == stt_pkg::CH_COLON) || (r_first == stt_pkg::CH_BANG))) begin
                do_append = 1'b1;
                n_mode    = M_SP2;
            end else begin
                emit_a   = 1'b1;
                do_start = 1'b1;
            end
        end else begin
            do_append = 1'b1;
        end

        if (do_clear) begin
            n_mode   = M_WAIT;
            n_count  = '0;
            n_offset = '0;
            n_first  = 8'h00;
            n_cand   = 4'hf;
            n_dod    = 1'b1;
            n_aon    = 1'b1;
            n_ovf    = 1'b0;
        end
        if (do_start) begin
            n_first  = i_byte;
            n_count  = ONE_CNT;
            n_offset = r_pos;
            n_cand   = {i_byte == 8'h66, i_byte == 8'h69, i_byte == 8'h69, i_byte == 8'h70};
            n_dod    = b_digit || (i_byte == stt_pkg::CH_DOT);
            n_aon    = b_alnum;
            n_ovf    = 1'b0;
        end
        if (do_append) begin
            for (int k = 0; k < 4; k++) begin
                if (!stt_pkg::kw_match(2'(k), 8'(r_count), i_byte))
                    n_cand[k] = 1'b0;
            end
            if (!(b_digit || (i_byte == stt_pkg::CH_DOT)))
                n_dod = 1'b0;
            if (!b_alnum)
                n_aon = 1'b0;
            if (r_count < MAX_CNT)
                n_count = r_count + ONE_CNT;
            else
                n_ovf = 1'b1;
        end

        // token from the lexeme that this byte closes
        len_a        = 32'(r_count);
        st_a         = 32'(r_offset);
        tok_a.kind   = stt_pkg::lexeme_kind(r_first, r_mode == M_SP2, r_cand, 8'(r_count),
                                            r_ovf, r_dod, r_aon);
        tok_a.start  = st_a[15:0];
        tok_a.length = len_a[5:0];
        tok_a.ovf    = r_ovf;

        // token flushed at end of text, taken from the updated lexeme
        emit_b       = i_last && (n_mode != M_WAIT);
        len_b        = 32'(n_count);
        st_b         = 32'(n_offset);
        tok_b.kind   = stt_pkg::lexeme_kind(n_first, n_mode == M_SP2, n_cand, 8'(n_count),
                                            n_ovf, n_dod, n_aon);
        tok_b.start  = st_b[15:0];
        tok_b.length = len_b[5:0];
        tok_b.ovf    = n_ovf;
        tok_b.last   = 1'b1;
        tok_a.last   = !emit_b;

        if (i_last) begin
            n_mode   = M_WAIT;
            n_count  = '0;
            n_offset = '0;
            n_first  = 8'h00;
            n_cand   = 4'hf;
            n_dod    = 1'b1;
            n_aon    = 1'b1;
            n_ovf    = 1'b0;
            n_pos    = '0;
        end

        o_push.cnt  = i_valid ? (2'(emit_a) + 2'(emit_b)) : 2'd0;
        o_push.tok0 = emit_a ? tok_a : tok_b;
        o_push.tok1 = tok_b;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= M_WAIT;
            r_count  <= '0;
            r_offset <= '0;
            r_pos    <= '0;
            r_first  <= 8'h00;
            r_cand   <= 4'hf;
            r_dod    <= 1'b1;
            r_aon    <= 1'b1;
            r_ovf    <= 1'b0;
        end else if (i_valid) begin
            r_mode   <= n_mode;
            r_count  <= n_count;
            r_offset <= n_offset;
            r_pos    <= n_pos;
            r_first  <= n_first;
            r_cand   <= n_cand;
            r_dod    <= n_dod;
            r_aon    <= n_aon;
            r_ovf    <= n_ovf;
        end
    end

    a_last_resets: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && i_last) |=> ((r_mode == M_WAIT) && (r_pos == '0)))
        else $error("lexer not back at rest after end of text");

    a_ovf_saturated: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovf |-> (r_count == MAX_CNT))
        else $error("overflow flag without saturated length");

    a_pair_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_mode == M_SP2) |-> (r_count == TWO_CNT))
        else $error("joined pair lexeme with length other than two");

endmodule

@@ rtl/stt_out_queue.sv @@
// four-entry token queue, takes up to two tokens per cycle and hands out one
// depends on stt_pkg
module stt_out_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  stt_pkg::t_push  i_push,
    output logic            o_room,
    output logic            o_valid,
    input  logic            i_ready,
    output stt_pkg::t_token o_tok
);

    stt_pkg::t_token r_mem [0:3];
    logic [1:0]      r_wr, r_rd;
    logic [2:0]      r_cnt, n_cnt;
    logic            pop;
    logic [1:0]      wr_next;

    assign o_valid = (r_cnt != 3'd0);
    assign o_room  = (r_cnt <= 3'd2);
    assign o_tok   = r_mem[r_rd];
    assign pop     = o_valid && i_ready;
    assign wr_next = r_wr + 2'd1;
    assign n_cnt   = r_cnt + 3'(i_push.cnt) - 3'(pop);

    always_ff @(posedge i_clk) begin
        if (i_push.cnt != 2'd0)
            r_mem[r_wr] <= i_push.tok0;
        if (i_push.cnt == 2'd2)
            r_mem[wr_next] <= i_push.tok1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 2'd0;
            r_rd  <= 2'd0;
            r_cnt <= 3'd0;
        end else begin
            r_wr  <= r_wr + i_push.cnt;
            r_rd  <= r_rd + 2'(pop);
            r_cnt <= n_cnt;
        end
    end

    a_no_overfill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= 3'd4)
        else $error("token queue holds more than four entries");

    a_push_with_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push.cnt != 2'd0) |-> o_room)
        else $error("tokens pushed into a full queue");

endmodule
